// File: rtl/tss_pkg.sv
// tss_pkg: shared widths, register indexes and pipeline word types for the
// triangle scanline span unit. No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package tss_pkg;

	// coordinate width of vertices, rows and span ends
	localparam int COORD_BITS = 10;
	// signed products of (COORD_BITS+1)-bit operands
	localparam int PROD_W     = 2 * COORD_BITS + 2;
	// divider numerator (edge numerator plus ceiling bias)
	localparam int NUM_W      = 2 * COORD_BITS + 1;
	// one quotient bit per divider stage
	localparam int DIV_STEPS  = COORD_BITS;
	// config port
	localparam int REG_IDX_W  = 3;
	localparam int ADDR_W     = REG_IDX_W + 2;
	localparam int DATA_W     = 32;

	typedef logic [COORD_BITS-1:0] coord_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_VERT_A_X = 3'd0,
		REG_VERT_A_Y = 3'd1,
		REG_VERT_B_X = 3'd2,
		REG_VERT_B_Y = 3'd3,
		REG_VERT_C_X = 3'd4,
		REG_VERT_C_Y = 3'd5
	} reg_idx_t;

	// stage 1: vertices sorted by y, row and its position
	typedef struct packed {
		coord_t xl;
		coord_t yl;
		coord_t xm;
		coord_t ym;
		coord_t xu;
		coord_t yu;
		coord_t row;
		logic   in_range;
		logic   lower;
	} sort_t;

	// stage 2: edge and side products
	typedef struct packed {
		logic signed [PROD_W-1:0] long_base;
		logic signed [PROD_W-1:0] long_step;
		logic signed [PROD_W-1:0] short_base;
		logic signed [PROD_W-1:0] short_step;
		logic signed [PROD_W-1:0] side_a;
		logic signed [PROD_W-1:0] side_b;
		coord_t                   dl;
		coord_t                   ds;
		logic                     in_range;
	} prod_t;

	// divider word: partial remainders, divisors, quotients for both edges
	typedef struct packed {
		logic [NUM_W-1:0] lrem;
		logic [NUM_W-1:0] rrem;
		coord_t           lden;
		coord_t           rden;
		coord_t           lq;
		coord_t           rq;
		logic             in_range;
	} div_t;

endpackage

`default_nettype wire

// File: rtl/tss_ifs.sv
// Valid/ready channel interfaces: row words in, span words out.
// Depends on tss_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tss_row_if;
	import tss_pkg::*;
	logic   valid;
	logic   ready;
	coord_t row;
	modport source (output valid, output row, input ready);
	modport sink (input valid, input row, output ready);
endinterface

interface tss_span_if;
	import tss_pkg::*;
	logic   valid;
	logic   ready;
	coord_t span_start;
	coord_t span_end;
	logic   covered;
	modport source (output valid, output span_start, output span_end, output covered,
		input ready);
	modport sink (input valid, input span_start, input span_end, input covered,
		output ready);
endinterface

`default_nettype wire

// File: rtl/triangle_scanline_span_unit.sv
// Triangle scanline span unit: per-row span of a triangle held in config.
// Depends on tss_pkg and tss_ifs (tss_row_if, tss_span_if).
//
// channel    | dir | payload                          | handshake
// row_in     | in  | row                              | valid/ready
// span_out   | out | span_start, span_end, covered    | valid/ready
// APB        | in  | six vertex registers at 4*i      | psel/penable, pready=1
//
// One word per cycle sustained while span_out is ready; stages in order: sort, multiply,
// sum, one divider stage per quotient bit, output register.
// Each stage holds its word only while the next is full, so bubbles collapse
// and the input takes a word while a finished span waits at the output.
// arst_n clears valid bits and vertex registers (all vertices at 0).
`timescale 1ns / 1ps
`default_nettype none

module triangle_scanline_span_unit (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire [tss_pkg::ADDR_W-1:0]    paddr,
	input  wire [tss_pkg::DATA_W-1:0]    pwdata,
	output logic [tss_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	tss_row_if.sink                      row_in,
	tss_span_if.source                   span_out
);
	import tss_pkg::*;

	// vertex registers
	coord_t ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
	reg_idx_t reg_idx;
	logic cfg_wr;

	// pipeline
	logic   v_s1, v_s2, v_s3, v_s5;
	logic   rdy_s1, rdy_s2, rdy_s3, rdy_s5;
	sort_t  sort_s1, sort_nxt;
	prod_t  prod_s2, prod_nxt;
	div_t   div_s3, div_nxt;
	logic   dv_s4 [DIV_STEPS];
	logic   drdy_s4 [DIV_STEPS];
	div_t   dstep_s4 [DIV_STEPS];
	div_t   dstep_nxt [DIV_STEPS];
	coord_t span_start_s5, span_end_s5;
	logic   covered_s5;

	// APB register file
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ax_q <= '0; ay_q <= '0;
			bx_q <= '0; by_q <= '0;
			cx_q <= '0; cy_q <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_VERT_A_X: ax_q <= pwdata[COORD_BITS-1:0];
				REG_VERT_A_Y: ay_q <= pwdata[COORD_BITS-1:0];
				REG_VERT_B_X: bx_q <= pwdata[COORD_BITS-1:0];
				REG_VERT_B_Y: by_q <= pwdata[COORD_BITS-1:0];
				REG_VERT_C_X: cx_q <= pwdata[COORD_BITS-1:0];
				REG_VERT_C_Y: cy_q <= pwdata[COORD_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_VERT_A_X: prdata = DATA_W'(ax_q);
			REG_VERT_A_Y: prdata = DATA_W'(ay_q);
			REG_VERT_B_X: prdata = DATA_W'(bx_q);
			REG_VERT_B_Y: prdata = DATA_W'(by_q);
			REG_VERT_C_X: prdata = DATA_W'(cx_q);
			REG_VERT_C_Y: prdata = DATA_W'(cy_q);
			default: prdata = '0;
		endcase
	end

	// ready chain: a stage takes a word when empty or when it moves on
	assign rdy_s5 = !v_s5 || span_out.ready;
	assign rdy_s3 = !v_s3 || drdy_s4[0];
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign row_in.ready = rdy_s1;

	// stage 1: stable three-way sort by y
	always_comb begin
		coord_t x0, y0, x1, y1, x2, y2, tx, ty;
		x0 = ax_q; y0 = ay_q;
		x1 = bx_q; y1 = by_q;
		x2 = cx_q; y2 = cy_q;
		tx = '0; ty = '0;
		if (y0 > y1) begin
			tx = x0; ty = y0; x0 = x1; y0 = y1; x1 = tx; y1 = ty;
		end
		if (y1 > y2) begin
			tx = x1; ty = y1; x1 = x2; y1 = y2; x2 = tx; y2 = ty;
		end
		if (y0 > y1) begin
			tx = x0; ty = y0; x0 = x1; y0 = y1; x1 = tx; y1 = ty;
		end
		sort_nxt.xl       = x0;
		sort_nxt.yl       = y0;
		sort_nxt.xm       = x1;
		sort_nxt.ym       = y1;
		sort_nxt.xu       = x2;
		sort_nxt.yu       = y2;
		sort_nxt.row      = row_in.row;
		sort_nxt.in_range = (row_in.row >= y0) && (row_in.row < y2);
		sort_nxt.lower    = row_in.row < y1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= row_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && row_in.valid) begin
			sort_s1 <= sort_nxt;
		end
	end

	// stage 2: edge numerator and cross product terms
	always_comb begin
		logic signed [COORD_BITS:0] xl, xm, xu, x0s, x1s, dl, ds, ryl, ry0, dxl, dxs, dxm, dym;
		xl  = $signed({1'b0, sort_s1.xl});
		xm  = $signed({1'b0, sort_s1.xm});
		xu  = $signed({1'b0, sort_s1.xu});
		dl  = $signed({1'b0, sort_s1.yu - sort_s1.yl});
		ryl = $signed({1'b0, sort_s1.row - sort_s1.yl});
		dxl = xu - xl;
		dxm = xm - xl;
		dym = $signed({1'b0, sort_s1.ym - sort_s1.yl});
		if (sort_s1.lower) begin
			x0s = xl;
			x1s = xm;
			ds  = dym;
			ry0 = ryl;
		end else begin
			x0s = xm;
			x1s = xu;
			ds  = $signed({1'b0, sort_s1.yu - sort_s1.ym});
			ry0 = $signed({1'b0, sort_s1.row - sort_s1.ym});
		end
		dxs = x1s - x0s;
		prod_nxt.long_base  = xl * dl;
		prod_nxt.long_step  = ryl * dxl;
		prod_nxt.short_base = x0s * ds;
		prod_nxt.short_step = ry0 * dxs;
		prod_nxt.side_a     = dxm * dl;
		prod_nxt.side_b     = dym * dxl;
		prod_nxt.dl         = dl[COORD_BITS-1:0];
		prod_nxt.ds         = ds[COORD_BITS-1:0];
		prod_nxt.in_range   = sort_s1.in_range;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			prod_s2 <= prod_nxt;
		end
	end

	// stage 3: sum numerators, pick sides, bias the left one for ceiling
	always_comb begin
		logic signed [PROD_W-1:0] nl, ns, side;
		logic [NUM_W-1:0] lnum, rnum;
		coord_t lden, rden;
		nl   = prod_s2.long_base + prod_s2.long_step;
		ns   = prod_s2.short_base + prod_s2.short_step;
		side = prod_s2.side_a - prod_s2.side_b;
		if (!side[PROD_W-1]) begin
			lnum = {1'b0, nl[NUM_W-2:0]};
			lden = prod_s2.dl;
			rnum = {1'b0, ns[NUM_W-2:0]};
			rden = prod_s2.ds;
		end else begin
			lnum = {1'b0, ns[NUM_W-2:0]};
			lden = prod_s2.ds;
			rnum = {1'b0, nl[NUM_W-2:0]};
			rden = prod_s2.dl;
		end
		// ceil(n/d) = floor((n + d - 1)/d); numerators are never negative
		div_nxt.lrem     = lnum + NUM_W'(lden) - NUM_W'(1);
		div_nxt.rrem     = rnum;
		div_nxt.lden     = lden;
		div_nxt.rden     = rden;
		div_nxt.lq       = '0;
		div_nxt.rq       = '0;
		div_nxt.in_range = prod_s2.in_range;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			div_s3 <= div_nxt;
		end
	end

	// stages 4..: restoring divider, one quotient bit per stage, MSB first
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		localparam int QB = DIV_STEPS - 1 - k;
		div_t din;
		logic vin;

		if (k == 0) begin : g_first
			assign din = div_s3;
			assign vin = v_s3;
		end else begin : g_next
			assign din = dstep_s4[k-1];
			assign vin = dv_s4[k-1];
		end

		if (k == DIV_STEPS - 1) begin : g_last
			assign drdy_s4[k] = !dv_s4[k] || rdy_s5;
		end else begin : g_mid
			assign drdy_s4[k] = !dv_s4[k] || drdy_s4[k+1];
		end

		always_comb begin
			logic [NUM_W:0] ltrial, rtrial;
			ltrial = {1'b0, din.lrem} - ((NUM_W + 1)'(din.lden) << QB);
			rtrial = {1'b0, din.rrem} - ((NUM_W + 1)'(din.rden) << QB);
			dstep_nxt[k] = din;
			if (!ltrial[NUM_W]) begin
				dstep_nxt[k].lrem   = ltrial[NUM_W-1:0];
				dstep_nxt[k].lq[QB] = 1'b1;
			end
			if (!rtrial[NUM_W]) begin
				dstep_nxt[k].rrem   = rtrial[NUM_W-1:0];
				dstep_nxt[k].rq[QB] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s4[k] <= 1'b0;
			end else if (drdy_s4[k]) begin
				dv_s4[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (drdy_s4[k] && vin) begin
				dstep_s4[k] <= dstep_nxt[k];
			end
		end
	end

	// output stage: empty-span check; quotients already lie on screen
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (rdy_s5) begin
			v_s5 <= dv_s4[DIV_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5 && dv_s4[DIV_STEPS-1]) begin
			if (dstep_s4[DIV_STEPS-1].in_range
				&& (dstep_s4[DIV_STEPS-1].lq < dstep_s4[DIV_STEPS-1].rq)) begin
				span_start_s5 <= dstep_s4[DIV_STEPS-1].lq;
				span_end_s5   <= dstep_s4[DIV_STEPS-1].rq;
				covered_s5    <= 1'b1;
			end else begin
				span_start_s5 <= '0;
				span_end_s5   <= '0;
				covered_s5    <= 1'b0;
			end
		end
	end

	assign span_out.valid      = v_s5;
	assign span_out.span_start = span_start_s5;
	assign span_out.span_end   = span_end_s5;
	assign span_out.covered    = covered_s5;

	// checks
	a_covered_order: assert property (@(posedge clk) disable iff (!arst_n)
		span_out.valid && span_out.covered |-> span_out.span_start < span_out.span_end)
		else $error("covered span with start not below end");

	a_uncovered_zero: assert property (@(posedge clk) disable iff (!arst_n)
		span_out.valid && !span_out.covered
		|-> span_out.span_start == '0 && span_out.span_end == '0)
		else $error("uncovered span with nonzero ends");

	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !drdy_s4[0] |=> v_s3 && $stable(div_s3))
		else $error("stage 3 word lost under stall");

endmodule

`default_nettype wire

// File: sim/tb_triangle_scanline_span_unit.sv
// Testbench for triangle_scanline_span_unit: drives row words, checks span words
// against an in-bench span predictor. Depends on tss_pkg, tss_ifs and the RTL.
`timescale 1ns / 1ps

module tb_triangle_scanline_span_unit;
	import tss_pkg::*;

	localparam int LATENCY   = COORD_BITS + 4;
	localparam int WDOG_MAX  = 5000;
	localparam int RAND_ROWS = 1000;

	typedef struct packed {
		coord_t span_start;
		coord_t span_end;
		logic   covered;
	} span_t;

	// one directed row: vertex set, row, and optional typed-in result
	typedef struct {
		coord_t ax, ay, bx, by, cx, cy;
		coord_t row;
		bit     has_exp;
		span_t  exp_span;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	tss_row_if  row_ch ();
	tss_span_if span_ch ();

	triangle_scanline_span_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.row_in   (row_ch.sink),
		.span_out (span_ch.source)
	);

	// vertex shadow and pending spans
	coord_t vtx_x[3];
	coord_t vtx_y[3];
	span_t  span_q[$];
	int     mismatches;
	int     idle_cycles;
	bit     hold_off;
	bit     timed_out;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// floor division by positive d
	function automatic longint fdiv(longint n, longint d);
		longint q;
		q = n / d;
		if ((n % d) != 0 && n < 0) q = q - 1;
		return q;
	endfunction

	// span of one row through the current triangle
	function automatic span_t row_span(coord_t row);
		longint x[3], y[3], t, r, dl, nl, ds, ns, side, ln, ld, rn, rd, s, e;
		span_t res;
		for (int i = 0; i < 3; i++) begin
			x[i] = vtx_x[i];
			y[i] = vtx_y[i];
		end
		for (int i = 1; i < 3; i++) begin
			for (int j = i; j > 0; j--) begin
				if (y[j-1] > y[j]) begin
					t = x[j]; x[j] = x[j-1]; x[j-1] = t;
					t = y[j]; y[j] = y[j-1]; y[j-1] = t;
				end
			end
		end
		res = '0;
		r = row;
		if (r >= y[0] && r < y[2]) begin
			dl = y[2] - y[0];
			nl = x[0] * dl + (r - y[0]) * (x[2] - x[0]);
			side = (x[1] - x[0]) * dl - (y[1] - y[0]) * (x[2] - x[0]);
			if (r < y[1]) begin
				ds = y[1] - y[0];
				ns = x[0] * ds + (r - y[0]) * (x[1] - x[0]);
			end else begin
				ds = y[2] - y[1];
				ns = x[1] * ds + (r - y[1]) * (x[2] - x[1]);
			end
			if (side >= 0) begin
				ln = nl; ld = dl; rn = ns; rd = ds;
			end else begin
				ln = ns; ld = ds; rn = nl; rd = dl;
			end
			s = -fdiv(-ln, ld);
			e = fdiv(rn, rd);
			if (s < e) begin
				if (s < 0) s = 0;
				if (s > 1023) s = 1023;
				if (e < 0) e = 0;
				if (e > 1023) e = 1023;
				res.span_start = coord_t'(s);
				res.span_end   = coord_t'(e);
				res.covered    = 1'b1;
			end
		end
		return res;
	endfunction

	// APB write, register written at the access edge
	task automatic reg_write(reg_idx_t idx, logic [DATA_W-1:0] val);
		@(negedge clk);
		psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
		paddr = ADDR_W'({idx, 2'b00}); pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
		case (idx)
			REG_VERT_A_X: vtx_x[0] = coord_t'(val);
			REG_VERT_A_Y: vtx_y[0] = coord_t'(val);
			REG_VERT_B_X: vtx_x[1] = coord_t'(val);
			REG_VERT_B_Y: vtx_y[1] = coord_t'(val);
			REG_VERT_C_X: vtx_x[2] = coord_t'(val);
			REG_VERT_C_Y: vtx_y[2] = coord_t'(val);
			default: ;
		endcase
	endtask

	// upper bits above the coordinate are set on purpose; they must be dropped
	task automatic set_triangle(coord_t ax, coord_t ay, coord_t bx, coord_t by,
			coord_t cx, coord_t cy);
		logic [DATA_W-1:0] junk;
		junk = {$urandom} & ~(DATA_W'((1 << COORD_BITS) - 1));
		reg_write(REG_VERT_A_X, junk | ax);
		reg_write(REG_VERT_A_Y, junk | ay);
		reg_write(REG_VERT_B_X, junk | bx);
		reg_write(REG_VERT_B_Y, junk | by);
		reg_write(REG_VERT_C_X, junk | cx);
		reg_write(REG_VERT_C_Y, junk | cy);
	endtask

	// stop offering, wait for all spans, drain the pipeline, end on a falling edge
	task automatic wait_idle();
		row_ch.valid = 1'b0;
		while (span_q.size() != 0 && !timed_out) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
		@(negedge clk);
	endtask

	// offer one row word, after a random gap if do_gap is set, return once accepted;
	// valid stays up so that the next word can follow with no gap
	task automatic send_row(coord_t row, bit do_gap);
		int gap;
		gap = do_gap ? $urandom_range(0, 6) : 0;
		if (gap != 0) begin
			row_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		row_ch.valid = 1'b1;
		row_ch.row   = row;
		span_q.push_back(row_span(row));
		@(posedge clk);
		while (!row_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// receiver: random stalls per word, plus forced long hold-offs
	initial begin
		int stall;
		span_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				span_ch.ready = 1'b0;
			end else begin
				stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
				if (stall != 0) begin
					span_ch.ready = 1'b0;
					repeat (stall) @(negedge clk);
					span_ch.ready = 1'b1;
				end else begin
					span_ch.ready = 1'b1;
				end
				@(posedge clk);
				while (!(span_ch.valid && span_ch.ready) && !hold_off) @(posedge clk);
			end
		end
	end

	// span checker
	always @(posedge clk) begin
		span_t exp_s, got;
		if (arst_n && span_ch.valid && span_ch.ready) begin
			got = '{span_ch.span_start, span_ch.span_end, span_ch.covered};
			if (span_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected span word: start %0d end %0d covered %0b",
						got.span_start, got.span_end, got.covered);
			end else begin
				exp_s = span_q.pop_front();
				if (got !== exp_s) begin
					mismatches++;
					if (mismatches <= 10)
						$display("span mismatch: exp %0d/%0d/%0b got %0d/%0d/%0b",
							exp_s.span_start, exp_s.span_end, exp_s.covered,
							got.span_start, got.span_end, got.covered);
				end
			end
		end
	end

	// watchdog on cycles with no accepted word, no APB access and spans still pending
	always @(posedge clk) begin
		if ((row_ch.valid && row_ch.ready) || (span_ch.valid && span_ch.ready)
				|| psel || span_q.size() == 0)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_MAX && !timed_out) begin
			timed_out = 1'b1;
			$display("** triangle_scanline_span_unit: FAILED **");
			$finish;
		end
	end

	dir_row_t dir_tab[$];

	function automatic dir_row_t mk(coord_t ax, coord_t ay, coord_t bx, coord_t by,
			coord_t cx, coord_t cy, coord_t row, bit he, span_t es);
		dir_row_t d;
		d = '{ax, ay, bx, by, cx, cy, row, he, es};
		return d;
	endfunction

	initial begin
		span_t z;
		dir_row_t d;
		coord_t cx0, cy0;
		int n;
		z = '0;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		row_ch.valid = 1'b0; row_ch.row = '0;
		mismatches = 0; idle_cycles = 0; hold_off = 1'b0; timed_out = 1'b0;
		for (int i = 0; i < 3; i++) begin
			vtx_x[i] = '0; vtx_y[i] = '0;
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset triangle is degenerate: no row covered
		send_row(10'd0, 1'b0);
		send_row(10'd1023, 1'b0);
		wait_idle();

		// directed: extremes, flat, collinear, both sides, ties
		dir_tab.push_back(mk(0, 0, 1023, 0, 0, 1023, 0, 1, '{0, 1023, 1}));
		dir_tab.push_back(mk(0, 0, 1023, 0, 0, 1023, 1022, 1, '{0, 1, 1}));
		dir_tab.push_back(mk(0, 0, 1023, 0, 0, 1023, 1023, 1, z));
		dir_tab.push_back(mk(1023, 0, 0, 1023, 1023, 1023, 512, 0, z));
		dir_tab.push_back(mk(1023, 0, 0, 1023, 1023, 1023, 0, 0, z));
		dir_tab.push_back(mk(5, 7, 900, 7, 300, 7, 7, 1, z));
		dir_tab.push_back(mk(0, 0, 500, 500, 1000, 1000, 250, 1, z));
		dir_tab.push_back(mk(100, 100, 900, 400, 300, 900, 400, 0, z));
		dir_tab.push_back(mk(100, 100, 900, 400, 300, 900, 399, 0, z));
		dir_tab.push_back(mk(100, 100, 900, 400, 300, 900, 99, 1, z));
		dir_tab.push_back(mk(100, 100, 900, 400, 300, 900, 900, 1, z));
		dir_tab.push_back(mk(900, 900, 10, 400, 700, 100, 500, 0, z));
		dir_tab.push_back(mk(900, 900, 10, 400, 700, 100, 100, 0, z));
		dir_tab.push_back(mk(3, 0, 7, 3, 1, 5, 2, 0, z));
		dir_tab.push_back(mk(512, 20, 513, 21, 511, 1000, 600, 0, z));
		dir_tab.push_back(mk(1023, 1023, 1023, 0, 0, 0, 0, 0, z));
		dir_tab.push_back(mk(1023, 1023, 1023, 0, 0, 0, 1023, 1, z));
		foreach (dir_tab[i]) begin
			d = dir_tab[i];
			if (i == 0 || d.ax != dir_tab[i-1].ax || d.ay != dir_tab[i-1].ay ||
					d.bx != dir_tab[i-1].bx || d.by != dir_tab[i-1].by ||
					d.cx != dir_tab[i-1].cx || d.cy != dir_tab[i-1].cy) begin
				wait_idle();
				set_triangle(d.ax, d.ay, d.bx, d.by, d.cx, d.cy);
			end
			send_row(d.row, 1'b1);
			// typed-in value replaces the predicted one
			if (d.has_exp) span_q[span_q.size()-1] = d.exp_span;
		end
		wait_idle();

		// random phases: new triangle, then rows mostly inside its y range
		n = 0;
		while (n < RAND_ROWS) begin
			wait_idle();
			cy0 = $urandom_range(0, 1023);
			cx0 = $urandom_range(0, 1023);
			case ($urandom_range(0, 3))
				0: set_triangle($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
				1: set_triangle(cx0, cy0, $urandom_range(0, 1023), cy0 + $urandom_range(0, 40),
						$urandom_range(0, 1023), cy0 + $urandom_range(0, 80));
				2: set_triangle(cx0, cy0, cx0 + 10'd1, cy0, $urandom, $urandom);
				default: set_triangle(10'd0, $urandom, 10'd1023, $urandom, $urandom, $urandom);
			endcase
			for (int k = 0; k < 40; k++) begin
				if ($urandom_range(0, 4) == 0)
					send_row($urandom_range(0, 1023), 1'b1);
				else
					send_row(coord_t'(vtx_y[$urandom_range(0, 2)] +
						$urandom_range(0, 60) - 10), 1'b1);
				n++;
			end
			// one long receiver hold-off with back-to-back rows
			if (n == 200) begin
				wait_idle();
				fork
					begin
						hold_off = 1'b1;
						repeat (3 * LATENCY) @(posedge clk);
						hold_off = 1'b0;
					end
					begin
						for (int k = 0; k < 3 * LATENCY; k++) begin
							send_row($urandom_range(0, 1023), 1'b0);
							n++;
						end
						row_ch.valid = 1'b0;
					end
				join
			end
		end

		wait_idle();
		if (mismatches == 0 && span_q.size() == 0)
			$display("** triangle_scanline_span_unit: PASSED **");
		else
			$display("** triangle_scanline_span_unit: FAILED **");
		$finish;
	end

endmodule
